// ===== src/lqm_pkg.sv =====
// ----------------------------------------------------------------------------
// lqm_pkg
// Shared types and constants of the linked queue manager: field widths,
// operation and status codes, and the item structs passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package lqm_pkg;

    localparam int POOL_SIZE_DEF  = 16;
    localparam int NUM_QUEUES_DEF = 4;

    localparam int FUNC_W     = 2;
    localparam int QID_W      = 2;
    localparam int ELEM_W     = 4;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;
    localparam int HEAD_W     = 4;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_STATUS = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_LINKED   = 3'd2,
        ST_UNLINKED = 3'd3,
        ST_OTHER    = 3'd4
    } t_status;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic [QID_W-1:0]  queue_id;
        logic [FUNC_W-1:0] func;
    } t_op;

    typedef struct packed {
        logic [HEAD_W-1:0] head_index;
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_result;

endpackage

`default_nettype wire

// ===== src/lqm_in_stage.sv =====
// ----------------------------------------------------------------------------
// lqm_in_stage
// Input register: holds one accepted request until the engine consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lqm_in_stage (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  lqm_pkg::t_op   i_op,
    input  wire            i_advance,
    output logic           o_valid,
    output lqm_pkg::t_op   o_op
);

    logic          r_valid;
    lqm_pkg::t_op  r_op;
    logic          load;

    // a held request leaves whenever the result side can take it
    assign o_ready = !r_valid || i_advance;
    assign load    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_op    = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_op <= i_op;
        end
    end

endmodule

`default_nettype wire

// ===== src/lqm_engine.sv =====
// ----------------------------------------------------------------------------
// lqm_engine
// Link tables and per-queue head and count; decodes one request, updates
// the rings in the same cycle and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module lqm_engine #(
    parameter int POOL_SIZE  = lqm_pkg::POOL_SIZE_DEF,
    parameter int NUM_QUEUES = lqm_pkg::NUM_QUEUES_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_fire,
    input  lqm_pkg::t_op       i_op,
    output lqm_pkg::t_result   o_result
);

    localparam int IDX_W = $clog2(POOL_SIZE);
    localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CW    = $clog2(POOL_SIZE + 1);

    logic [IDX_W-1:0] r_next   [POOL_SIZE];
    logic [IDX_W-1:0] r_prev   [POOL_SIZE];
    logic [QW-1:0]    r_owner  [POOL_SIZE];
    logic             r_linked [POOL_SIZE];
    logic [IDX_W-1:0] r_head   [NUM_QUEUES];
    logic [CW-1:0]    r_count  [NUM_QUEUES];

    logic [IDX_W-1:0] e_idx;
    logic [QW-1:0]    q_idx;
    logic             q_ok;
    logic             e_ok;
    logic [CW-1:0]    cnt;
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] last;
    logic [IDX_W-1:0] nx;
    logic [IDX_W-1:0] pv;
    logic             lnk;
    logic [QW-1:0]    own;
    logic             do_app;
    logic             do_rem;
    lqm_pkg::t_status status;
    logic [CW-1:0]    n_cnt;
    logic [IDX_W-1:0] n_head;

    assign e_idx = IDX_W'(i_op.element);
    assign q_idx = QW'(i_op.queue_id);
    assign q_ok  = 32'(i_op.queue_id) < NUM_QUEUES;
    assign e_ok  = 32'(i_op.element) < POOL_SIZE;

    always_comb begin
        cnt    = q_ok ? r_count[q_idx] : '0;
        head   = r_head[q_idx];
        last   = r_prev[head];
        nx     = r_next[e_idx];
        pv     = r_prev[e_idx];
        lnk    = e_ok ? r_linked[e_idx] : 1'b0;
        own    = r_owner[e_idx];
        do_app = 1'b0;
        do_rem = 1'b0;
        status = lqm_pkg::ST_OK;
        if (!q_ok) begin
            status = lqm_pkg::ST_EMPTY;
        end else begin
            unique case (lqm_pkg::t_func'(i_op.func))
                lqm_pkg::FUNC_APPEND: begin
                    if (!e_ok) begin
                        status = lqm_pkg::ST_UNLINKED;
                    end else if (lnk) begin
                        status = lqm_pkg::ST_LINKED;
                    end else begin
                        do_app = 1'b1;
                    end
                end
                lqm_pkg::FUNC_REMOVE: begin
                    // range check comes before the empty check
                    if (!e_ok) begin
                        status = lqm_pkg::ST_UNLINKED;
                    end else if (cnt == '0) begin
                        status = lqm_pkg::ST_EMPTY;
                    end else if (!lnk) begin
                        status = lqm_pkg::ST_UNLINKED;
                    end else if (own != q_idx) begin
                        status = lqm_pkg::ST_OTHER;
                    end else begin
                        do_rem = 1'b1;
                    end
                end
                default: begin
                    status = lqm_pkg::ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        if (do_app) begin
            n_cnt = cnt + CW'(1);
        end else if (do_rem) begin
            n_cnt = cnt - CW'(1);
        end else begin
            n_cnt = cnt;
        end
        if (do_app && cnt == '0) begin
            n_head = e_idx;
        end else if (do_rem && head == e_idx) begin
            n_head = nx;
        end else begin
            n_head = head;
        end
    end

    assign o_result.status     = status;
    assign o_result.count      = lqm_pkg::COUNT_W'(n_cnt);
    assign o_result.head_index = (n_cnt != '0) ? lqm_pkg::HEAD_W'(n_head) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_SIZE; i++) begin
                r_linked[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_count[i] <= '0;
            end
        end else if (i_fire) begin
            if (do_app) begin
                r_linked[e_idx] <= 1'b1;
            end
            if (do_rem) begin
                r_linked[e_idx] <= 1'b0;
            end
            if (do_app || do_rem) begin
                r_count[q_idx] <= n_cnt;
            end
        end
    end

    // link payload, valid only where the linked flag or count says so
    always_ff @(posedge i_clk) begin
        if (i_fire && do_app) begin
            r_owner[e_idx] <= q_idx;
            r_head[q_idx]  <= n_head;
            if (cnt == '0) begin
                r_next[e_idx] <= e_idx;
                r_prev[e_idx] <= e_idx;
            end else begin
                r_next[last]  <= e_idx;
                r_prev[head]  <= e_idx;
                r_next[e_idx] <= head;
                r_prev[e_idx] <= last;
            end
        end
        if (i_fire && do_rem && cnt != CW'(1)) begin
            // unlink from the ring, neighbors close the gap
            r_next[pv]    <= nx;
            r_prev[nx]    <= pv;
            r_head[q_idx] <= n_head;
        end
    end

`ifndef SYNTHESIS
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && do_app |=>
            r_count[$past(q_idx)] == $past(cnt) + CW'(1))
        else $error("append did not grow the queue count");

    a_remove_unlinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && do_rem |=> !r_linked[$past(e_idx)] &&
            r_count[$past(q_idx)] == $past(cnt) - CW'(1))
        else $error("remove left the slot linked or count unchanged");

    a_fail_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && q_ok && status != lqm_pkg::ST_OK |=>
            r_count[$past(q_idx)] == $past(cnt))
        else $error("failed request changed the queue count");

    a_ok_app_unlinked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && do_app |=> r_linked[$past(e_idx)] &&
            r_owner[$past(e_idx)] == $past(q_idx))
        else $error("appended slot not tagged with its queue");
`endif

endmodule

`default_nettype wire

// ===== src/lqm_out_stage.sv =====
// ----------------------------------------------------------------------------
// lqm_out_stage
// Result register: holds a finished result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lqm_out_stage (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_load,
    input  lqm_pkg::t_result   i_result,
    output logic               o_can_load,
    output logic               o_valid,
    input  wire                i_ready,
    output lqm_pkg::t_result   o_result
);

    logic              r_valid;
    lqm_pkg::t_result  r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== src/linked_queue_manager_core.sv =====
// ----------------------------------------------------------------------------
// linked_queue_manager_core
// Circular doubly linked queues over a shared pool of element slots.
// ----------------------------------------------------------------------------
// usage
//   slave channel: one request per beat, tdata = func, queue_id, element.
//     func 0 appends the element at the queue tail, 1 removes it from
//     wherever it sits, 2 (and 3) only reads the queue status.
//   master channel: one result per request, in order, tdata = status,
//     count after the request, and head_index (zero when the queue is empty).
//   path: an accepted request is registered in the input register, processed
//     by the engine, and its result registered in the result register once
//     that register can take it; the result then waits there for tready.
//   throughput: one request per cycle while the receiver keeps tready high;
//     the whole update is a single pass of table reads and writes on the
//     flip-flop link tables between the input and result registers.
//   stall: when the receiver holds tready low the result register keeps its
//     beat; the input register still takes one more request, then tready on
//     the slave side drops until the result leaves.
//   reset: synchronous, active low; every queue comes out empty and no slot
//     is linked, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_queue_manager_core #(
    parameter int POOL_SIZE  = lqm_pkg::POOL_SIZE_DEF,
    parameter int NUM_QUEUES = lqm_pkg::NUM_QUEUES_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_tvalid,
    output logic                            o_s_tready,
    // [1:0] func, [3:2] queue_id, [7:4] element
    input  wire  [lqm_pkg::IN_DATA_W-1:0]   i_s_tdata,
    output logic                            o_m_tvalid,
    input  wire                             i_m_tready,
    // [2:0] status, [7:3] count, [11:8] head_index, [15:12] zero
    output logic [lqm_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    lqm_pkg::t_op      in_op;
    lqm_pkg::t_op      op;
    logic              op_valid;
    logic              can_load;
    logic              fire;
    lqm_pkg::t_result  result;
    lqm_pkg::t_result  out_result;

    assign in_op = lqm_pkg::t_op'(i_s_tdata);
    assign fire  = op_valid && can_load;

    lqm_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_op      (in_op),
        .i_advance (can_load),
        .o_valid   (op_valid),
        .o_op      (op)
    );

    lqm_engine #(
        .POOL_SIZE  (POOL_SIZE),
        .NUM_QUEUES (NUM_QUEUES)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_op     (op),
        .o_result (result)
    );

    lqm_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_result   (result),
        .o_can_load (can_load),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_result   (out_result)
    );

    assign o_m_tdata = {{(lqm_pkg::OUT_DATA_W - $bits(lqm_pkg::t_result)){1'b0}}, out_result};

endmodule

`default_nettype wire
